// ===== design/ebp_pkg.sv =====
// shared types, register indexes and saturation helpers for the error bar projector
package ebp_pkg;

  // one input word: data point and per-axis errors, signed fixed point
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] x_err_low;
    logic signed [31:0] x_err_high;
    logic signed [31:0] y_err_low;
    logic signed [31:0] y_err_high;
    logic signed [31:0] z_err_low;
    logic signed [31:0] z_err_high;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [1:0]         point_kind;
    logic [1:0]         bar_axis;
    logic signed [31:0] ndc_x;
    logic signed [31:0] ndc_y;
    logic               last_point;
  } out_word_t;

  // control that travels with a projection through the pipeline
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] axis;
    logic       is_hi;
    logic       last;
  } job_tag_t;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_OFFSET = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_A     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_B     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_A     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_B     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_A     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_B     = 4'd7;

  localparam logic [1:0] KIND_MARKER = 2'd0;
  localparam logic [1:0] KIND_BAR    = 2'd1;
  localparam logic [1:0] KIND_CAP    = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;

  // clamp a 34-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // clamp a 64-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== design/ebp_div.sv =====
// pipelined signed fixed-point divider pair sharing one divisor, four quotient bits per stage
module ebp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  ebp_pkg::job_tag_t  in_tag,
  input  logic signed [31:0] num_x,
  input  logic signed [31:0] num_y,
  input  logic signed [31:0] den,
  output logic               out_valid,
  output ebp_pkg::job_tag_t  out_tag,
  output logic signed [31:0] q_x,
  output logic signed [31:0] q_y
);
  import ebp_pkg::*;

  localparam int NW    = 32 + FRAC_BITS;
  localparam int STEPS = 4;
  localparam int STG   = (NW + STEPS - 1) / STEPS;
  localparam int NP    = STG * STEPS;

  logic              v_r    [STG+1];
  job_tag_t          tag_r  [STG+1];
  logic [NP-1:0]     nx_r   [STG+1];
  logic [NP-1:0]     ny_r   [STG+1];
  logic [NP-1:0]     qx_r   [STG+1];
  logic [NP-1:0]     qy_r   [STG+1];
  logic [31:0]       rx_r   [STG+1];
  logic [31:0]       ry_r   [STG+1];
  logic [31:0]       d_r    [STG+1];
  logic              negx_r [STG+1];
  logic              negy_r [STG+1];
  logic              zero_r [STG+1];

  logic [31:0] abs_x, abs_y, abs_d;

  // magnitudes and result signs
  always_comb begin
    abs_x = num_x[31] ? (~num_x + 32'd1) : num_x;
    abs_y = num_y[31] ? (~num_y + 32'd1) : num_y;
    abs_d = den[31] ? (~den + 32'd1) : den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0]  <= in_tag;
      nx_r[0]   <= NP'(abs_x) << FRAC_BITS;
      ny_r[0]   <= NP'(abs_y) << FRAC_BITS;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      rx_r[0]   <= '0;
      ry_r[0]   <= '0;
      d_r[0]    <= abs_d;
      negx_r[0] <= num_x[31] ^ den[31];
      negy_r[0] <= num_y[31] ^ den[31];
      zero_r[0] <= (den == 32'sd0);
    end
  end

  // restoring division stages
  for (genvar s = 1; s <= STG; s++) begin : g_stage
    logic [NP-1:0] nx_c, ny_c, qx_c, qy_c;
    logic [32:0]   rx_c, ry_c;

    always_comb begin
      nx_c = nx_r[s-1];
      ny_c = ny_r[s-1];
      qx_c = qx_r[s-1];
      qy_c = qy_r[s-1];
      rx_c = {1'b0, rx_r[s-1]};
      ry_c = {1'b0, ry_r[s-1]};
      for (int k = 0; k < STEPS; k++) begin
        rx_c = {rx_c[31:0], nx_c[NP-1]};
        ry_c = {ry_c[31:0], ny_c[NP-1]};
        nx_c = nx_c << 1;
        ny_c = ny_c << 1;
        if (rx_c >= {1'b0, d_r[s-1]}) begin
          rx_c = rx_c - {1'b0, d_r[s-1]};
          qx_c = {qx_c[NP-2:0], 1'b1};
        end else begin
          qx_c = {qx_c[NP-2:0], 1'b0};
        end
        if (ry_c >= {1'b0, d_r[s-1]}) begin
          ry_c = ry_c - {1'b0, d_r[s-1]};
          qy_c = {qy_c[NP-2:0], 1'b1};
        end else begin
          qy_c = {qy_c[NP-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s]  <= tag_r[s-1];
        nx_r[s]   <= nx_c;
        ny_r[s]   <= ny_c;
        qx_r[s]   <= qx_c;
        qy_r[s]   <= qy_c;
        rx_r[s]   <= rx_c[31:0];
        ry_r[s]   <= ry_c[31:0];
        d_r[s]    <= d_r[s-1];
        negx_r[s] <= negx_r[s-1];
        negy_r[s] <= negy_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
    end
  end

  // sign and saturate the quotients
  function automatic logic signed [31:0] fix_q(input logic [NP-1:0] q, input logic neg,
                                               input logic zero);
    logic signed [31:0] r;
    if (zero) r = 32'sd0;
    else if (neg) begin
      if (q > NP'(33'h0_8000_0000)) r = 32'sh8000_0000;
      else r = ~q[31:0] + 32'd1;
    end else begin
      if (q > NP'(33'h0_7FFF_FFFF)) r = 32'sh7FFF_FFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

  logic               out_v_r;
  job_tag_t           out_tag_r;
  logic signed [31:0] qx_out_r, qy_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag_r <= tag_r[STG];
      qx_out_r  <= fix_q(qx_r[STG], negx_r[STG], zero_r[STG]);
      qy_out_r  <= fix_q(qy_r[STG], negy_r[STG], zero_r[STG]);
    end
  end

  assign out_valid = out_v_r;
  assign out_tag   = out_tag_r;
  assign q_x       = qx_out_r;
  assign q_y       = qy_out_r;

endmodule

// ===== design/error_bar_projector_3d_core.sv =====
// top level: job issue, projection pipeline and result word sequencing
//
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   ebp_pkg::in_word_t
// out_     output     out_valid / out_ready ebp_pkg::out_word_t
// cfg_     input      cfg_we                cfg_index, cfg_data (64 bits)
//
// each input word becomes up to seven projections (marker, two per drawn axis),
// issued one a cycle into the pipeline unless it stalls; the result side emits
// one word a cycle while out_ready is high, so how long a word takes is set by
// the count of result words it yields. reset is synchronous and restores the
// identity matrix rows and default modes. an out_ready stall freezes the pipeline
// once a result waits at the divider output; nothing is dropped or repeated.
module error_bar_projector_3d_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ebp_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ebp_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [ebp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);
  import ebp_pkg::*;

  localparam logic [2:0] STEP_BAR      = 3'd0;
  localparam logic [2:0] STEP_LO_MINUS = 3'd1;
  localparam logic [2:0] STEP_LO_PLUS  = 3'd2;
  localparam logic [2:0] STEP_HI_MINUS = 3'd3;
  localparam logic [2:0] STEP_HI_PLUS  = 3'd4;

  // configuration registers
  logic [1:0]  draw_mode_r;
  logic [30:0] cap_r;
  logic [63:0] mat_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_mode_r <= 2'd1;
      cap_r       <= 31'd3277;
      mat_r[0]    <= 64'd65536;
      mat_r[1]    <= 64'd0;
      mat_r[2]    <= 64'd281474976710656;
      mat_r[3]    <= 64'd0;
      mat_r[4]    <= 64'd0;
      mat_r[5]    <= 64'd281474976710656;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRAW_MODE:  draw_mode_r <= cfg_data[1:0];
        REG_CAP_OFFSET: cap_r       <= cfg_data[30:0];
        REG_ROW0_A:     mat_r[0]    <= cfg_data;
        REG_ROW0_B:     mat_r[1]    <= cfg_data;
        REG_ROW1_A:     mat_r[2]    <= cfg_data;
        REG_ROW1_B:     mat_r[3]    <= cfg_data;
        REG_ROW3_A:     mat_r[4]    <= cfg_data;
        REG_ROW3_B:     mat_r[5]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // matrix entries: rows 0, 1 and 3 as rows 0..2 here
  logic signed [31:0] ent [3][4];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ent[r][0] = mat_r[2*r][31:0];
      ent[r][1] = mat_r[2*r][63:32];
      ent[r][2] = mat_r[2*r+1][31:0];
      ent[r][3] = mat_r[2*r+1][63:32];
    end
  end

  // issue unit: held word and mask of projections still to send
  in_word_t   item_r;
  logic       item_v_r;
  logic [6:0] mask_r;
  logic [6:0] new_mask, pick, rest;
  logic [2:0] job;
  logic       pipe_en, issue_fire, in_fire;

  always_comb begin
    new_mask[0] = draw_mode_r[0];
    new_mask[1] = (in_data.x_err_low > 32'sd0) || (in_data.x_err_high > 32'sd0);
    new_mask[2] = new_mask[1];
    new_mask[3] = (in_data.y_err_low > 32'sd0) || (in_data.y_err_high > 32'sd0);
    new_mask[4] = new_mask[3];
    new_mask[5] = (in_data.z_err_low > 32'sd0) || (in_data.z_err_high > 32'sd0);
    new_mask[6] = new_mask[5];
    pick = '0;
    job  = '0;
    for (int i = 6; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = 7'(1) << i;
        job  = 3'(i);
      end
    end
    rest = mask_r & ~pick;
  end

  assign issue_fire = item_v_r && pipe_en;
  assign in_ready   = !item_v_r || (issue_fire && (rest == '0));
  assign in_fire    = in_valid && in_ready;

  // a new word replaces the mask; otherwise the issued bit is cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      mask_r   <= '0;
    end else if (in_fire) begin
      mask_r   <= new_mask;
      item_v_r <= |new_mask;
    end else if (issue_fire) begin
      mask_r   <= rest;
      item_v_r <= |rest;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
  end

  // endpoint of the chosen projection
  logic [1:0]         j_axis;
  logic               j_hi;
  logic signed [31:0] j_base, j_err, j_moved;
  logic signed [31:0] j_pt [3];
  job_tag_t           j_tag;

  always_comb begin
    j_axis = 2'((job - 3'd1) >> 1);
    j_hi   = (job != 3'd0) && !job[0];
    case (j_axis)
      2'd0:    begin j_base = item_r.pos_x; j_err = j_hi ? item_r.x_err_high : item_r.x_err_low; end
      2'd1:    begin j_base = item_r.pos_y; j_err = j_hi ? item_r.y_err_high : item_r.y_err_low; end
      default: begin j_base = item_r.pos_z; j_err = j_hi ? item_r.z_err_high : item_r.z_err_low; end
    endcase
    j_moved = j_hi ? sat34(34'(j_base) + 34'(j_err)) : sat34(34'(j_base) - 34'(j_err));
    j_pt[0] = item_r.pos_x;
    j_pt[1] = item_r.pos_y;
    j_pt[2] = item_r.pos_z;
    if (job != 3'd0) j_pt[j_axis] = j_moved;
    j_tag.kind  = (job == 3'd0) ? KIND_MARKER : KIND_BAR;
    j_tag.axis  = (job == 3'd0) ? AXIS_X : j_axis;
    j_tag.is_hi = j_hi;
    j_tag.last  = (rest == '0);
  end

  // stage 1: point register
  logic               s1_v_r;
  job_tag_t           s1_tag_r;
  logic signed [31:0] s1_pt_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (pipe_en) s1_v_r <= item_v_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_tag_r <= j_tag;
      for (int c = 0; c < 3; c++) s1_pt_r[c] <= j_pt[c];
    end
  end

  // stage 2: nine products
  logic               s2_v_r;
  job_tag_t           s2_tag_r;
  logic signed [63:0] prod_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (pipe_en) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_tag_r <= s1_tag_r;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          prod_r[r][c] <= 64'(ent[r][c]) * 64'(s1_pt_r[c]);
    end
  end

  // stage 3: row sums with floor shift and saturation
  logic               s3_v_r;
  job_tag_t           s3_tag_r;
  logic signed [31:0] clip_r [3];
  logic signed [63:0] row_sum [3];

  always_comb begin
    for (int r = 0; r < 3; r++)
      row_sum[r] = (prod_r[r][0] >>> FRAC_BITS) + (prod_r[r][1] >>> FRAC_BITS)
                 + (prod_r[r][2] >>> FRAC_BITS) + 64'(ent[r][3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (pipe_en) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_tag_r <= s2_tag_r;
      for (int r = 0; r < 3; r++) clip_r[r] <= sat64(row_sum[r]);
    end
  end

  // perspective divide
  logic               dv_v;
  job_tag_t           dv_tag;
  logic signed [31:0] dv_x, dv_y;

  ebp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (s3_v_r),
    .in_tag    (s3_tag_r),
    .num_x     (clip_r[0]),
    .num_y     (clip_r[1]),
    .den       (clip_r[2]),
    .out_valid (dv_v),
    .out_tag   (dv_tag),
    .q_x       (dv_x),
    .q_y       (dv_y)
  );

  // result sequencer: one projection becomes one marker or bar word, or a bar plus caps
  logic               job_v_r;
  job_tag_t           job_tag_r;
  logic signed [31:0] jx_r, jy_r, lox_r, loy_r;
  logic [2:0]         step_r;
  logic               caps_on, fin, out_fire, fmt_take;

  assign caps_on  = draw_mode_r[1] && job_tag_r.is_hi && (job_tag_r.kind == KIND_BAR);
  assign fin      = !caps_on || (step_r == STEP_HI_PLUS);
  assign out_fire = job_v_r && out_ready;
  assign fmt_take = dv_v && (!job_v_r || (out_fire && fin));
  assign pipe_en  = !dv_v || fmt_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      step_r  <= STEP_BAR;
    end else if (fmt_take) begin
      job_v_r <= 1'b1;
      step_r  <= STEP_BAR;
    end else if (out_fire) begin
      if (fin) job_v_r <= 1'b0;
      else step_r <= step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fmt_take) begin
      job_tag_r <= dv_tag;
      jx_r      <= dv_x;
      jy_r      <= dv_y;
      if (dv_tag.kind == KIND_BAR && !dv_tag.is_hi) begin
        lox_r <= dv_x;
        loy_r <= dv_y;
      end
    end
  end

  // word formation with cap offsets
  logic signed [31:0] bx, by, off;
  logic               minus;

  always_comb begin
    out_data.bar_axis   = job_tag_r.axis;
    out_data.last_point = job_tag_r.last && fin;
    bx    = jx_r;
    by    = jy_r;
    minus = 1'b0;
    case (step_r)
      STEP_LO_MINUS: begin bx = lox_r; by = loy_r; minus = 1'b1; end
      STEP_LO_PLUS:  begin bx = lox_r; by = loy_r; end
      STEP_HI_MINUS: minus = 1'b1;
      default: ;
    endcase
    if (job_tag_r.axis == AXIS_X) begin
      off = by;
    end else begin
      off = bx;
    end
    off = minus ? sat34(34'(off) - 34'(cap_r)) : sat34(34'(off) + 34'(cap_r));
    if (step_r == STEP_BAR) begin
      out_data.point_kind = job_tag_r.kind;
      out_data.ndc_x      = jx_r;
      out_data.ndc_y      = jy_r;
    end else begin
      out_data.point_kind = KIND_CAP;
      out_data.ndc_x      = (job_tag_r.axis == AXIS_X) ? bx : off;
      out_data.ndc_y      = (job_tag_r.axis == AXIS_X) ? off : by;
    end
  end

  assign out_valid = job_v_r;

endmodule
